### hdl/sorted_unique_set_defines.svh
// Assertion macros shared by the sorted_unique_set RTL.
`ifndef SORTED_UNIQUE_SET_DEFINES_SVH
`define SORTED_UNIQUE_SET_DEFINES_SVH

// Same-cycle implication, sampled on clock, muted during reset.
`define SUS_CHECK_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sorted_unique_set: check failed");

// Next-cycle implication, sampled on clock, muted during reset.
`define SUS_CHECK_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sorted_unique_set: check failed");

`endif

### hdl/sus_pkg.sv
// Shared constants and controller/datapath interface types for sorted_unique_set.
`timescale 1ns / 1ps
package sus_pkg;

   // store size and field widths
   localparam int CAPACITY = 32;
   localparam int VALUE_W  = 31;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   // controller to datapath commands
   typedef struct packed {
      logic accept;    // a word is taken this cycle: insert it if nonzero, new and not full
      logic dump_arm;  // the word ends a line: latch drop flag, rewind index
      logic step;      // one dump word goes out this cycle
   } sus_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic last;      // current dump word is the final one
   } sus_status_type;

endpackage

### hdl/sus_ctrl.sv
// Controller state machine: input acceptance and dump sequencing.
`timescale 1ns / 1ps
module sus_ctrl
   import sus_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic           req_line_end,
   input  sus_status_type status,
   output sus_cmd_type    cmd,
   output logic           busy,
   output logic           rsp_strobe
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_DUMP = 2'b10
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   // handshake and commands
   assign busy       = (state_ff == ST_DUMP);
   assign rsp_strobe = (state_ff == ST_DUMP);
   assign accept     = start & ~busy;

   always_comb begin
      cmd.accept   = accept;
      cmd.dump_arm = accept & req_line_end;
      cmd.step     = (state_ff == ST_DUMP);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_line_end) begin
               state_in = ST_DUMP;
            end
         end
         ST_DUMP: begin
            if (status.last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### hdl/sus_dpath.sv
// Datapath: chain of compare-and-shift cells, count, overflow flag and dump index.
`timescale 1ns / 1ps
`include "sorted_unique_set_defines.svh"
module sus_dpath
   import sus_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  sus_cmd_type        cmd,
   input  logic [VALUE_W-1:0] req_value,
   output sus_status_type     status,
   output logic [VALUE_W-1:0] rsp_number,
   output logic               rsp_set_empty,
   output logic               rsp_dropped,
   output logic               rsp_last
);

   logic [VALUE_W-1:0] entries_ff   [CAPACITY];
   logic [VALUE_W-1:0] entries_in   [CAPACITY];
   logic [VALUE_W-1:0] entries_prev [CAPACITY];
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   logic [IDX_W-1:0]   idx_ff;
   logic [IDX_W-1:0]   idx_in;
   logic               ovf_ff;
   logic               ovf_in;
   logic               drop_ff;
   logic               drop_in;

   logic [CAPACITY-1:0] valid;
   logic [CAPACITY-1:0] gt;
   logic [CAPACITY-1:0] gt_prev;
   logic [CAPACITY-1:0] eq;
   logic                dup;
   logic                full;
   logic                nonzero;
   logic                do_insert;
   logic                overflow_now;
   logic                empty;
   logic                last;
   logic                order_ok;

   // per-cell compare against the incoming word
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         valid[i] = (CNT_W'(i) < count_ff);
         gt[i]    = valid[i] && (entries_ff[i] > req_value);
         eq[i]    = valid[i] && (entries_ff[i] == req_value);
      end
      gt_prev[0]      = 1'b0;
      entries_prev[0] = '0;
      for (int i = 1; i < CAPACITY; i++) begin
         gt_prev[i]      = gt[i-1];
         entries_prev[i] = entries_ff[i-1];
      end
   end

   assign dup          = |eq;
   assign nonzero      = (req_value != '0);
   assign full         = (count_ff == CNT_W'(CAPACITY));
   assign do_insert    = cmd.accept && nonzero && !dup && !full;
   assign overflow_now = cmd.accept && nonzero && !dup && full;

   // shift larger entries up by one, drop the word into the gap
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         entries_in[i] = entries_ff[i];
         if (do_insert) begin
            if (gt_prev[i]) begin
               entries_in[i] = entries_prev[i];
            end else if (gt[i] || (CNT_W'(i) == count_ff)) begin
               entries_in[i] = req_value;
            end
         end
      end
   end

   // count, overflow and dump bookkeeping
   always_comb begin
      count_in = count_ff;
      ovf_in   = ovf_ff;
      drop_in  = drop_ff;
      idx_in   = idx_ff;
      if (do_insert) begin
         count_in = count_ff + CNT_W'(1);
      end
      if (cmd.dump_arm) begin
         drop_in = ovf_ff | overflow_now;
         ovf_in  = 1'b0;
         idx_in  = '0;
      end else if (cmd.accept) begin
         ovf_in = ovf_ff | overflow_now;
      end else if (cmd.step) begin
         idx_in = idx_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      entries_ff <= entries_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         drop_ff  <= 1'b0;
         idx_ff   <= '0;
      end else begin
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         drop_ff  <= drop_in;
         idx_ff   <= idx_in;
      end
   end

   // result word
   assign empty         = (count_ff == '0);
   assign last          = empty || ((CNT_W'(idx_ff) + CNT_W'(1)) == count_ff);
   assign status.last   = last;
   assign rsp_number    = empty ? '0 : entries_ff[idx_ff];
   assign rsp_set_empty = empty;
   assign rsp_dropped   = drop_ff;
   assign rsp_last      = last;

   // stored entries stay strictly ascending
   always_comb begin
      order_ok = 1'b1;
      for (int i = 1; i < CAPACITY; i++) begin
         if (valid[i] && (entries_ff[i-1] >= entries_ff[i])) begin
            order_ok = 1'b0;
         end
      end
   end

   `SUS_CHECK_NOW(a_sorted, 1'b1, order_ok)
   `SUS_CHECK_NOW(a_count_bound, 1'b1, count_ff <= CNT_W'(CAPACITY))
   `SUS_CHECK_NEXT(a_insert_grows, do_insert, count_ff == $past(count_ff) + CNT_W'(1))
   `SUS_CHECK_NEXT(a_dump_frozen, cmd.step && !last, $stable(count_ff) && !$stable(idx_ff))

endmodule

### hdl/sorted_unique_set.sv
// Top level of sorted_unique_set: controller plus insertion-cell datapath.
`timescale 1ns / 1ps
//
// Keeps a set of distinct nonzero 31-bit numbers in ascending order.
// Input: a word (req_value, req_line_end) is taken at a rising edge where
// start is high and busy is low. Zero and numbers already held are ignored;
// a new number is placed at its sorted position in the same cycle by a row
// of compare-and-shift cells. When the store is full a new number is
// discarded and remembered as a drop until the next dump.
// Output: when req_line_end is set, busy rises on the next cycle and the
// whole set streams out, smallest first, one word per cycle on rsp_* with
// rsp_strobe high and rsp_last on the final word. An empty set gives one
// word with rsp_set_empty high. rsp_dropped is the same on every word of
// a dump. The set is kept across dumps.
// Rate: words without line end are taken one per cycle while busy is low.
// A word with line end is followed by a dump of one word per stored
// entry (one if the set is empty), read through the dump index, during
// which busy is high. The first result appears the cycle after acceptance.
// Reset (synchronous) empties the set and clears the drop flag.
// The receiver cannot stall: each result is valid for exactly one cycle.
//
module sorted_unique_set
   import sus_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [VALUE_W-1:0] req_value,
   input  logic               req_line_end,
   output logic               rsp_strobe,
   output logic [VALUE_W-1:0] rsp_number,
   output logic               rsp_set_empty,
   output logic               rsp_dropped,
   output logic               rsp_last
);

   sus_cmd_type    cmd;
   sus_status_type status;

   sus_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .req_line_end (req_line_end),
      .status       (status),
      .cmd          (cmd),
      .busy         (busy),
      .rsp_strobe   (rsp_strobe)
   );

   sus_dpath u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_value     (req_value),
      .status        (status),
      .rsp_number    (rsp_number),
      .rsp_set_empty (rsp_set_empty),
      .rsp_dropped   (rsp_dropped),
      .rsp_last      (rsp_last)
   );

endmodule
